// File: sv/multi_team_life_cell_rule_core_macros.svh
// Assertion macros shared by the life rule core RTL.
// Included by the modules that carry concurrent checks; needs no package.
`ifndef MULTI_TEAM_LIFE_CELL_RULE_CORE_MACROS_SVH
`define MULTI_TEAM_LIFE_CELL_RULE_CORE_MACROS_SVH

// same-cycle implication under synchronous reset
`define MTL_ASSERT_IMPLIES(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication under synchronous reset
`define MTL_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/mtl_pkg.sv
// Types, constants and helper functions for the multi-team life rule core.
// No dependencies; imported by the interfaces and every module.
`timescale 1ns / 1ps
`default_nettype none

package mtl_pkg;

   localparam int unsigned CODE_W         = 4;
   localparam int unsigned TEAM_W         = 3;
   localparam int unsigned CNT_W          = 4;
   localparam int unsigned NBR_COUNT      = 8;
   localparam int unsigned NBRS_PER_STAGE = 2;
   localparam int unsigned SCAN_STAGES    = NBR_COUNT / NBRS_PER_STAGE;
   localparam int unsigned ALIVE_BIT      = 0;

   typedef logic [CODE_W-1:0]          code_type;
   typedef logic [TEAM_W-1:0]          team_type;
   typedef logic [CNT_W-1:0]           count_type;
   typedef code_type [NBR_COUNT-1:0]   nbr_vec_type;

   localparam count_type SURVIVE_MIN = count_type'(2);
   localparam count_type SURVIVE_MAX = count_type'(3);
   localparam count_type BIRTH_COUNT = count_type'(3);
   localparam team_type  TEAM_NONE   = team_type'(0);

   // running scan state that travels down the pipeline with each cell
   typedef struct packed {
      code_type  cur;
      count_type live_total;
      team_type  best_team;
      count_type best_score;
      logic      live_tie;
      team_type  dead_team;
      count_type dead_score;
      logic      dead_tie;
   } track_type;

   function automatic team_type mtl_team(input code_type c);
      return c[CODE_W-1:1];
   endfunction

   function automatic code_type mtl_code(input team_type t, input logic alive);
      return {t, alive};
   endfunction

   // fold an out-of-range team to team 0, keep the alive bit
   function automatic code_type mtl_norm(input code_type c, input int unsigned team_count);
      code_type r;
      r = c;
      if (32'(mtl_team(c)) >= team_count) begin
         r = mtl_code(TEAM_NONE, c[ALIVE_BIT]);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// File: sv/mtl_if.sv
// Valid/ready channel interfaces for the life rule core: neighborhood in, cell out.
// Depends on mtl_pkg for the code type.
`timescale 1ns / 1ps
`default_nettype none

interface mtl_req_if import mtl_pkg::*; ();
   logic     valid;
   logic     ready;
   code_type cell_now;
   code_type nbr_up_left;
   code_type nbr_up;
   code_type nbr_up_right;
   code_type nbr_right;
   code_type nbr_down_right;
   code_type nbr_down;
   code_type nbr_down_left;
   code_type nbr_left;

   modport source (
      output valid, cell_now, nbr_up_left, nbr_up, nbr_up_right, nbr_right,
             nbr_down_right, nbr_down, nbr_down_left, nbr_left,
      input  ready
   );
   modport sink (
      input  valid, cell_now, nbr_up_left, nbr_up, nbr_up_right, nbr_right,
             nbr_down_right, nbr_down, nbr_down_left, nbr_left,
      output ready
   );
endinterface

interface mtl_rsp_if import mtl_pkg::*; ();
   logic     valid;
   logic     ready;
   code_type cell_next;

   modport source (output valid, cell_next, input ready);
   modport sink (input valid, cell_next, output ready);
endinterface

`default_nettype wire

// File: sv/mtl_scan_stage.sv
// One pipeline stage of the neighbor scan: folds two neighbors into the counts
// and leader trackers. Depends on mtl_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "multi_team_life_cell_rule_core_macros.svh"

module mtl_scan_stage import mtl_pkg::*; #(
   parameter int unsigned TEAM_COUNT = 5,
   parameter int unsigned FIRST      = 0
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              up_valid,
   output logic                              up_ready,
   input  nbr_vec_type                       up_nbrs,
   input  track_type                         up_track,
   input  logic [TEAM_COUNT-1:0][CNT_W-1:0]  up_live,
   input  logic [TEAM_COUNT-1:0][CNT_W-1:0]  up_dead,
   output logic                              dn_valid,
   input  logic                              dn_ready,
   output nbr_vec_type                       dn_nbrs,
   output track_type                         dn_track,
   output logic [TEAM_COUNT-1:0][CNT_W-1:0]  dn_live,
   output logic [TEAM_COUNT-1:0][CNT_W-1:0]  dn_dead
);

   logic                             valid_ff;
   nbr_vec_type                      nbrs_ff;
   track_type                        track_ff, track_in;
   logic [TEAM_COUNT-1:0][CNT_W-1:0] live_ff, live_in;
   logic [TEAM_COUNT-1:0][CNT_W-1:0] dead_ff, dead_in;
   code_type                         c;
   count_type                        sel;

   // take a new item when empty or when the downstream transfer frees the slot
   assign up_ready = !valid_ff || dn_ready;

   always_comb begin
      track_in = up_track;
      live_in  = up_live;
      dead_in  = up_dead;
      c        = '0;
      sel      = '0;
      for (int k = 0; k < NBRS_PER_STAGE; k++) begin
         c   = mtl_norm(up_nbrs[FIRST + k], TEAM_COUNT);
         sel = '0;
         if (c[ALIVE_BIT]) begin
            track_in.live_total = track_in.live_total + 1'b1;
            for (int j = 0; j < TEAM_COUNT; j++) begin
               if (mtl_team(c) == team_type'(j)) begin
                  live_in[j] = live_in[j] + 1'b1;
                  sel        = live_in[j];
               end
            end
            if (sel > track_in.best_score) begin
               track_in.live_tie   = 1'b0;
               track_in.best_score = sel;
               track_in.best_team  = mtl_team(c);
            end else if (sel == track_in.best_score) begin
               track_in.live_tie = 1'b1;
            end
         end else if (mtl_team(c) != TEAM_NONE) begin
            for (int j = 0; j < TEAM_COUNT; j++) begin
               if (mtl_team(c) == team_type'(j)) begin
                  dead_in[j] = dead_in[j] + 1'b1;
                  sel        = dead_in[j];
               end
            end
            if (sel > track_in.dead_score) begin
               track_in.dead_tie   = 1'b0;
               track_in.dead_score = sel;
               track_in.dead_team  = mtl_team(c);
            end else if (sel == track_in.dead_score) begin
               track_in.dead_tie = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready) begin
         nbrs_ff  <= up_nbrs;
         track_ff <= track_in;
         live_ff  <= live_in;
         dead_ff  <= dead_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_nbrs  = nbrs_ff;
   assign dn_track = track_ff;
   assign dn_live  = live_ff;
   assign dn_dead  = dead_ff;

   `MTL_ASSERT_IMPLIES(a_score_le_total, clock, reset, valid_ff, track_ff.best_score <= track_ff.live_total, "leading live count exceeds live total")
   `MTL_ASSERT_IMPLIES(a_lead_nonzero, clock, reset, valid_ff && !track_ff.live_tie, track_ff.best_score != '0, "live leader without a count")
   `MTL_ASSERT_NEXT(a_stall_hold, clock, reset, valid_ff && !dn_ready, valid_ff && $stable(track_ff), "stalled stage lost its scan state")

endmodule

`default_nettype wire

// File: sv/mtl_decide.sv
// Output stage: applies B3/S23 and the team choice, registers the result.
// Depends on mtl_pkg, mtl_rsp_if and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "multi_team_life_cell_rule_core_macros.svh"

module mtl_decide import mtl_pkg::*; #(
   parameter int unsigned TEAM_COUNT = 5
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       up_valid,
   output logic       up_ready,
   input  track_type  up_track,
   mtl_rsp_if.source  rsp_if
);

   logic      valid_ff;
   code_type  cell_ff, cell_in;
   code_type  cur;
   count_type tot;

   assign up_ready = !valid_ff || rsp_if.ready;

   always_comb begin
      cur = mtl_norm(up_track.cur, TEAM_COUNT);
      tot = up_track.live_total;
      if (cur[ALIVE_BIT]) begin
         if (tot == SURVIVE_MIN || tot == SURVIVE_MAX) begin
            cell_in = mtl_code(up_track.best_team, 1'b1);
         end else if (!up_track.live_tie) begin
            cell_in = mtl_code(up_track.best_team, 1'b0);
         end else if (!up_track.dead_tie) begin
            cell_in = mtl_code(up_track.dead_team, 1'b0);
         end else begin
            cell_in = mtl_code(mtl_team(cur), 1'b0);
         end
      end else if (tot == BIRTH_COUNT) begin
         cell_in = up_track.live_tie ? mtl_code(TEAM_NONE, 1'b1)
                                     : mtl_code(up_track.best_team, 1'b1);
      end else begin
         // tied or empty neighborhood: keep the dead cell as it is; else take the live leader's team, still dead
         cell_in = up_track.live_tie ? cur : mtl_code(up_track.best_team, 1'b0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready) begin
         cell_ff <= cell_in;
      end
   end

   assign rsp_if.valid     = valid_ff;
   assign rsp_if.cell_next = cell_ff;

   `MTL_ASSERT_IMPLIES(a_team_range, clock, reset, valid_ff, 32'(mtl_team(cell_ff)) < TEAM_COUNT, "result team out of range")
   `MTL_ASSERT_NEXT(a_load, clock, reset, up_valid && up_ready, valid_ff, "accepted cell did not reach the output register")
   `MTL_ASSERT_IMPLIES(a_empty_ready, clock, reset, !valid_ff, up_ready, "empty output stage refuses a transfer")

endmodule

`default_nettype wire

// File: sv/multi_team_life_cell_rule_core.sv
// Multi-team life rule core: next-generation cell code from a 3x3 neighborhood.
// Depends on mtl_pkg, mtl_if, mtl_scan_stage and mtl_decide.
//
// req_if carries one cell code and its eight neighbor codes per transfer
// (bit 0 alive, bits 3:1 team). rsp_if returns the next cell code.
// The neighbors are scanned in fixed order through four register stages, two
// neighbors each, keeping live/dead counts per team and the two leader
// trackers; a fifth stage applies B3/S23 and picks the team.
// An accepted cell passes the four scan stage registers and the decide register
// before it is shown on rsp_if. Throughput: one cell per clock while rsp_if.ready
// stays high.
// Every stage has its own valid bit and takes a new cell when it is empty or
// its content moves on, so bubbles are squeezed out.
// Reset clears all valid bits; the pipeline is empty and ready right after.
// When the receiver holds rsp_if.ready low, the result stays on the port and
// the stall moves back stage by stage; req_if.ready drops only once every
// stage holds a cell. No cell is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module multi_team_life_cell_rule_core import mtl_pkg::*; #(
   parameter int unsigned TEAM_COUNT = 5
) (
   input  logic      clock,
   input  logic      reset,
   mtl_req_if.sink   req_if,
   mtl_rsp_if.source rsp_if
);

   logic                             valid [SCAN_STAGES+1];
   logic                             ready [SCAN_STAGES+1];
   nbr_vec_type                      nbrs  [SCAN_STAGES+1];
   track_type                        track [SCAN_STAGES+1];
   logic [TEAM_COUNT-1:0][CNT_W-1:0] live  [SCAN_STAGES+1];
   logic [TEAM_COUNT-1:0][CNT_W-1:0] dead  [SCAN_STAGES+1];

   assign valid[0]     = req_if.valid;
   assign req_if.ready = ready[0];

   assign nbrs[0][0] = req_if.nbr_up_left;
   assign nbrs[0][1] = req_if.nbr_up;
   assign nbrs[0][2] = req_if.nbr_up_right;
   assign nbrs[0][3] = req_if.nbr_right;
   assign nbrs[0][4] = req_if.nbr_down_right;
   assign nbrs[0][5] = req_if.nbr_down;
   assign nbrs[0][6] = req_if.nbr_down_left;
   assign nbrs[0][7] = req_if.nbr_left;

   // both tie flags start set, no leader yet
   assign track[0] = '{cur:        req_if.cell_now,
                       live_total: '0,
                       best_team:  TEAM_NONE,
                       best_score: '0,
                       live_tie:   1'b1,
                       dead_team:  TEAM_NONE,
                       dead_score: '0,
                       dead_tie:   1'b1};
   assign live[0] = '0;
   assign dead[0] = '0;

   for (genvar s = 0; s < SCAN_STAGES; s++) begin : g_scan
      mtl_scan_stage #(
         .TEAM_COUNT (TEAM_COUNT),
         .FIRST      (s * NBRS_PER_STAGE)
      ) u_stage (
         .clock    (clock),
         .reset    (reset),
         .up_valid (valid[s]),
         .up_ready (ready[s]),
         .up_nbrs  (nbrs[s]),
         .up_track (track[s]),
         .up_live  (live[s]),
         .up_dead  (dead[s]),
         .dn_valid (valid[s+1]),
         .dn_ready (ready[s+1]),
         .dn_nbrs  (nbrs[s+1]),
         .dn_track (track[s+1]),
         .dn_live  (live[s+1]),
         .dn_dead  (dead[s+1])
      );
   end

   mtl_decide #(
      .TEAM_COUNT (TEAM_COUNT)
   ) u_decide (
      .clock    (clock),
      .reset    (reset),
      .up_valid (valid[SCAN_STAGES]),
      .up_ready (ready[SCAN_STAGES]),
      .up_track (track[SCAN_STAGES]),
      .rsp_if   (rsp_if)
   );

endmodule

`default_nettype wire

// File: verif/multi_team_life_cell_rule_core_tb.sv
// Testbench for multi_team_life_cell_rule_core: streams 3x3 neighborhoods and
// compares each next cell code against an in-bench prediction of the rule.
// Depends on mtl_pkg, mtl_if and the core RTL.
`timescale 1ns / 1ps

module multi_team_life_cell_rule_core_tb;
   import mtl_pkg::*;

   localparam int unsigned TEAM_COUNT  = 5;
   localparam int unsigned QUIET_LIMIT = 5000;
   localparam int unsigned PHASE_CELLS = 400;

   // Predicts next codes and holds them until the core returns them.
   class cell_scoreboard;
      code_type    next_q[$];
      int unsigned errors;

      // out-of-range team reads as team 0 with the same alive bit
      function code_type fold(code_type raw);
         if (int'(raw[CODE_W-1:1]) >= TEAM_COUNT) return {3'b000, raw[0]};
         return raw;
      endfunction

      function code_type next_gen(code_type cell_code, nbr_vec_type nbrs);
         int unsigned live_hits[8];
         int unsigned dead_hits[8];
         int unsigned live_sum;
         int unsigned lead_score;
         int unsigned fade_score;
         team_type    lead_team;
         team_type    fade_team;
         bit          lead_tie;
         bit          fade_tie;
         code_type    cur;
         code_type    c;
         team_type    t;
         live_sum   = 0;
         lead_score = 0;
         fade_score = 0;
         lead_team  = '0;
         fade_team  = '0;
         lead_tie   = 1'b1;
         fade_tie   = 1'b1;
         for (int k = 0; k < 8; k++) begin
            live_hits[k] = 0;
            dead_hits[k] = 0;
         end
         cur = fold(cell_code);
         for (int k = 0; k < NBR_COUNT; k++) begin
            c = fold(nbrs[k]);
            t = c[CODE_W-1:1];
            if (c[0]) begin
               live_sum++;
               live_hits[t]++;
               if (live_hits[t] > lead_score) begin
                  lead_tie   = 1'b0;
                  lead_score = live_hits[t];
                  lead_team  = t;
               end else if (live_hits[t] == lead_score) begin
                  lead_tie = 1'b1;
               end
            end else if (t != '0) begin
               dead_hits[t]++;
               if (dead_hits[t] > fade_score) begin
                  fade_tie   = 1'b0;
                  fade_score = dead_hits[t];
                  fade_team  = t;
               end else if (dead_hits[t] == fade_score) begin
                  fade_tie = 1'b1;
               end
            end
         end
         if (cur[0]) begin
            if (live_sum == 2 || live_sum == 3) return {lead_team, 1'b1};
            if (!lead_tie) return {lead_team, 1'b0};
            if (!fade_tie) return {fade_team, 1'b0};
            return {cur[CODE_W-1:1], 1'b0};
         end
         if (live_sum == 3) return lead_tie ? code_type'(1) : {lead_team, 1'b1};
         return lead_tie ? cur : {lead_team, 1'b0};
      endfunction

      function void note_cell(code_type cell_code, nbr_vec_type nbrs);
         next_q.push_back(next_gen(cell_code, nbrs));
      endfunction

      function void check_cell(code_type got);
         code_type want;
         if (next_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected cell_next, expected none, actual %h", $time, got);
            return;
         end
         want = next_q.pop_front();
         if (got !== want) begin
            errors++;
            $display("%0t: cell_next mismatch, expected %h, actual %h", $time, want, got);
         end
      endfunction

      function int unsigned pending();
         return next_q.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   mtl_req_if req_bus ();
   mtl_rsp_if rsp_bus ();

   multi_team_life_cell_rule_core #(
      .TEAM_COUNT(TEAM_COUNT)
   ) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus.sink),
      .rsp_if (rsp_bus.source)
   );

   cell_scoreboard book;
   int unsigned    idle_pct;
   int unsigned    stall_pct;
   int unsigned    quiet_cycles = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // result side: check every transfer, then pick next cycle's ready
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) book.check_cell(rsp_bus.cell_next);
      rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
          (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   function automatic nbr_vec_type scan8(int unsigned a, int unsigned b, int unsigned c,
                                         int unsigned d, int unsigned e, int unsigned f,
                                         int unsigned g, int unsigned h);
      nbr_vec_type v;
      v[0] = code_type'(a);
      v[1] = code_type'(b);
      v[2] = code_type'(c);
      v[3] = code_type'(d);
      v[4] = code_type'(e);
      v[5] = code_type'(f);
      v[6] = code_type'(g);
      v[7] = code_type'(h);
      return v;
   endfunction

   // mostly one or two teams so leads and ties both come up
   function automatic nbr_vec_type rand_nbhd();
      nbr_vec_type v;
      int unsigned live_pct;
      team_type    ta;
      team_type    tb;
      team_type    t;
      int unsigned pick;
      case ($urandom_range(3))
         0: live_pct = 20;
         1: live_pct = 35;
         2: live_pct = 50;
         default: live_pct = 80;
      endcase
      ta = team_type'($urandom_range(TEAM_COUNT - 1));
      tb = team_type'($urandom_range(TEAM_COUNT - 1));
      for (int k = 0; k < NBR_COUNT; k++) begin
         pick = $urandom_range(9);
         if (pick == 0) t = team_type'($urandom_range(7));
         else if (pick < 6) t = ta;
         else t = tb;
         v[k] = {t, ($urandom_range(99) < live_pct)};
      end
      return v;
   endfunction

   task automatic send_cell(code_type cell_code, nbr_vec_type nbrs);
      while ($urandom_range(99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.cell_now       <= cell_code;
      req_bus.nbr_up_left    <= nbrs[0];
      req_bus.nbr_up         <= nbrs[1];
      req_bus.nbr_up_right   <= nbrs[2];
      req_bus.nbr_right      <= nbrs[3];
      req_bus.nbr_down_right <= nbrs[4];
      req_bus.nbr_down       <= nbrs[5];
      req_bus.nbr_down_left  <= nbrs[6];
      req_bus.nbr_left       <= nbrs[7];
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      book.note_cell(cell_code, nbrs);
   endtask

   // hold the sender until every predicted code has come back
   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (book.pending() != 0) @(posedge clock);
   endtask

   initial begin
      book         = new;
      idle_pct     = 0;
      stall_pct    = 0;
      reset        = 1'b1;
      req_bus.valid          <= 1'b0;
      req_bus.cell_now       <= '0;
      req_bus.nbr_up_left    <= '0;
      req_bus.nbr_up         <= '0;
      req_bus.nbr_up_right   <= '0;
      req_bus.nbr_right      <= '0;
      req_bus.nbr_down_right <= '0;
      req_bus.nbr_down       <= '0;
      req_bus.nbr_down_left  <= '0;
      req_bus.nbr_left       <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // rule corners: survival, birth, lead vs tie, dead-team fallback, folding
      send_cell(4'h0, scan8(0, 0, 0, 0, 0, 0, 0, 0));
      send_cell(4'hf, scan8(15, 15, 15, 15, 15, 15, 15, 15));
      send_cell(4'h1, scan8(3, 3, 0, 0, 0, 0, 0, 0));
      send_cell(4'h5, scan8(3, 5, 7, 0, 0, 0, 0, 0));
      send_cell(4'h0, scan8(3, 5, 5, 0, 0, 0, 0, 0));
      send_cell(4'h0, scan8(3, 5, 7, 0, 0, 0, 0, 0));
      send_cell(4'h4, scan8(3, 5, 0, 0, 0, 0, 0, 0));
      send_cell(4'h4, scan8(3, 3, 0, 0, 0, 0, 0, 0));
      send_cell(4'h9, scan8(0, 0, 0, 3, 0, 0, 0, 0));
      send_cell(4'h9, scan8(3, 5, 3, 5, 6, 6, 8, 0));
      send_cell(4'h9, scan8(6, 8, 0, 0, 0, 0, 0, 0));
      send_cell(4'h9, scan8(0, 0, 0, 0, 0, 0, 0, 0));
      send_cell(4'he, scan8(0, 2, 4, 6, 8, 10, 12, 14));
      send_cell(4'hc, scan8(11, 11, 0, 0, 0, 0, 0, 0));
      send_cell(4'h1, scan8(13, 15, 3, 0, 0, 0, 0, 0));
      send_cell(4'h6, scan8(3, 5, 5, 3, 0, 0, 0, 0));
      send_cell(4'h8, scan8(3, 5, 3, 9, 0, 0, 0, 0));
      send_cell(4'h7, scan8(1, 1, 1, 1, 1, 1, 1, 1));
      send_cell(4'h2, scan8(10, 12, 14, 0, 0, 0, 0, 0));
      send_cell(4'h9, scan8(0, 0, 0, 0, 0, 3, 3, 3));
      send_cell(4'hb, scan8(9, 9, 7, 7, 7, 9, 0, 0));
      send_cell(4'hd, scan8(1, 0, 3, 0, 0, 0, 0, 0));
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 52; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 52; end
            default: begin idle_pct = 21; stall_pct = 21; end
         endcase
         repeat (PHASE_CELLS) begin
            // a share of pure noise over the full 4-bit code space
            if ($urandom_range(9) < 2) begin
               send_cell(code_type'($urandom_range(15)), nbr_vec_type'($urandom));
            end else begin
               send_cell(code_type'($urandom_range(15)), rand_nbhd());
            end
         end
         drain();
      end

      stall_pct = 0;
      repeat (10) @(posedge clock);
      if (book.errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+sv
sv/mtl_pkg.sv
sv/mtl_if.sv
sv/mtl_scan_stage.sv
sv/mtl_decide.sv
sv/multi_team_life_cell_rule_core.sv
verif/multi_team_life_cell_rule_core_tb.sv
